// ===== design/sm4_block_cipher_defines.svh =====
// Assertion macros for the SM4 block cipher
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
`define SM4_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sm4 assertion failed");
`define SM4_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sm4 forbidden condition");
`else
`define SM4_ASSERT(lbl, prop)
`define SM4_NEVER(lbl, cond)
`endif

`endif

// ===== design/sm4_pkg.sv =====
package sm4_pkg;

	localparam int unsigned NUM_ROUNDS = 32;
	localparam int unsigned NUM_REGS   = 3;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_ENC_MODE = 2'd2
	} cfg_reg_t;

	localparam logic [31:0] FK_0 = 32'ha3b1bac6;
	localparam logic [31:0] FK_1 = 32'h56aa3350;
	localparam logic [31:0] FK_2 = 32'h677d9197;
	localparam logic [31:0] FK_3 = 32'hb27022dc;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] lin_data(input logic [31:0] b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// CK byte j of word i = (4i + j) * 7 mod 256, MSB first
	function automatic logic [31:0] ck_word(input logic [4:0] i);
		logic [31:0] w;
		logic [7:0]  b;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			b = 8'({1'b0, i, j[1:0]} * 8'd7);
			w = {w[23:0], b};
		end
		return w;
	endfunction

	// state word order {x0, x1, x2, x3}, x0 in the top bits
	function automatic logic [127:0] data_round(input logic [127:0] x, input logic [31:0] rk);
		logic [31:0] nx;
		nx = x[127:96] ^ lin_data(tau(x[95:64] ^ x[63:32] ^ x[31:0] ^ rk));
		return {x[95:0], nx};
	endfunction

endpackage

// ===== design/sm4_block_cipher.sv =====
// Channel  Signals                         Payload
// s        s_tvalid s_tready s_tdata s_tlast  block_high, block_low; final_block
// m        m_tvalid m_tready m_tdata m_tlast  result_high, result_low; final_out
// cfg      cfg_we cfg_index cfg_data        key_high, key_low, mode bit
//
// One block per cycle through 32 round stages while the keys are ready and m does not stall.
// After reset and after each register write the round keys are expanded one
// per cycle; s_tready stays low until the expansion is done.
// A stall at m holds the whole round pipeline; no block is lost or repeated.
// arst_n clears valid bits and key-schedule control; keys are re-expanded.
`include "sm4_block_cipher_defines.svh"

module sm4_block_cipher (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] block_high, [127:64] block_low
	input  logic         s_tlast,   // final_block
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] result_high, [127:64] result_low
	output logic         m_tlast    // final_out
);

	localparam int unsigned NR = sm4_pkg::NUM_ROUNDS;

	logic [63:0]  key_high_q;
	logic [63:0]  key_low_q;
	logic         enc_q;
	logic         cfg_hit;

	logic [31:0]  round_key_q [NR];
	logic [31:0]  kw_q [4];
	logic [4:0]   kcnt_q;
	logic         kbusy_q;
	logic         kload_q;
	logic         keys_ready_q;
	logic [31:0]  knext;
	logic [4:0]   kidx;

	logic [127:0] blk_s [NR];
	logic         last_s [NR];
	logic         vld_s [NR];
	logic         adv;
	logic [127:0] x_in;

	// registers
	assign cfg_hit = cfg_we && (cfg_index == sm4_pkg::REG_KEY_HIGH ||
		cfg_index == sm4_pkg::REG_KEY_LOW || cfg_index == sm4_pkg::REG_ENC_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			enc_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sm4_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				sm4_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				sm4_pkg::REG_ENC_MODE: enc_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key schedule, one round key per cycle
	assign knext = kw_q[0] ^ sm4_pkg::lin_key(sm4_pkg::tau(
		kw_q[1] ^ kw_q[2] ^ kw_q[3] ^ sm4_pkg::ck_word(kcnt_q)));
	assign kidx  = enc_q ? kcnt_q : ~kcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q       <= '0;
			kbusy_q      <= 1'b0;
			kload_q      <= 1'b1;
			keys_ready_q <= 1'b0;
		end else begin
			if (kload_q) begin
				kcnt_q  <= '0;
				kbusy_q <= 1'b1;
				kload_q <= 1'b0;
			end else if (kbusy_q) begin
				kcnt_q <= kcnt_q + 5'd1;
				if (kcnt_q == 5'(NR - 1)) begin
					kbusy_q      <= 1'b0;
					keys_ready_q <= 1'b1;
				end
			end
			if (cfg_hit) begin
				kload_q      <= 1'b1;
				kbusy_q      <= 1'b0;
				keys_ready_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (kload_q) begin
			kw_q[0] <= key_high_q[63:32] ^ sm4_pkg::FK_0;
			kw_q[1] <= key_high_q[31:0]  ^ sm4_pkg::FK_1;
			kw_q[2] <= key_low_q[63:32]  ^ sm4_pkg::FK_2;
			kw_q[3] <= key_low_q[31:0]   ^ sm4_pkg::FK_3;
		end else if (kbusy_q) begin
			kw_q[0] <= kw_q[1];
			kw_q[1] <= kw_q[2];
			kw_q[2] <= kw_q[3];
			kw_q[3] <= knext;
			round_key_q[kidx] <= knext;
		end
	end

	// round pipeline
	assign adv      = !vld_s[NR-1] || m_tready;
	assign s_tready = keys_ready_q && adv;
	assign x_in     = {s_tdata[63:32], s_tdata[31:0], s_tdata[127:96], s_tdata[95:64]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NR; r++) vld_s[r] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_tvalid && s_tready;
			for (int r = 1; r < NR; r++) vld_s[r] <= vld_s[r-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s[0]  <= sm4_pkg::data_round(x_in, round_key_q[0]);
			last_s[0] <= s_tlast;
			for (int r = 1; r < NR; r++) begin
				blk_s[r]  <= sm4_pkg::data_round(blk_s[r-1], round_key_q[r]);
				last_s[r] <= last_s[r-1];
			end
		end
	end

	// output words in reverse order
	assign m_tvalid = vld_s[NR-1];
	assign m_tlast  = last_s[NR-1];
	assign m_tdata  = {blk_s[NR-1][95:64], blk_s[NR-1][127:96],
		blk_s[NR-1][31:0], blk_s[NR-1][63:32]};

	`SM4_NEVER(a_no_accept_without_keys, s_tvalid && s_tready && !keys_ready_q)
	`SM4_ASSERT(a_cfg_clears_keys, cfg_hit |=> !keys_ready_q && kload_q)
	`SM4_ASSERT(a_sched_done, kbusy_q && kcnt_q == 5'(NR - 1) && !cfg_hit |=> keys_ready_q)
	`SM4_NEVER(a_load_excl_ready, kload_q && keys_ready_q)

endmodule

// ===== tb/sm4_block_cipher_check.sv =====
module sm4_block_cipher_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] block_high, [127:64] block_low
	input  logic         s_tlast,   // final_block
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,   // [63:0] result_high, [127:64] result_low
	input  logic         m_tlast,   // final_out
	output int unsigned  mismatches,
	output int unsigned  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        last;
	} cipher_block_t;

	logic [63:0]   key_hi = '0;
	logic [63:0]   key_lo = '0;
	logic          encrypt = 1'b1;
	logic          keys_valid = 1'b0;
	logic [31:0]   subkeys [32];
	cipher_block_t results_due [$];
	cipher_block_t want;

	function automatic logic [31:0] sbox_word(input logic [31:0] v);
		logic [31:0] w;
		for (int n = 0; n < 4; n++)
			w[8*n +: 8] = sm4_pkg::SBOX[v[8*n +: 8]];
		return w;
	endfunction

	function automatic logic [31:0] mix_data(input logic [31:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]} ^
			{b[7:0], b[31:8]};
	endfunction

	function automatic logic [31:0] mix_key(input logic [31:0] b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

	function automatic logic [31:0] ck_const(input int i);
		logic [31:0] w;
		w = '0;
		for (int j = 0; j < 4; j++)
			w = {w[23:0], 8'((4 * i + j) * 7)};
		return w;
	endfunction

	function void expand_subkeys();
		logic [31:0] k [4];
		logic [31:0] nk;
		k[0] = key_hi[63:32] ^ sm4_pkg::FK_0;
		k[1] = key_hi[31:0] ^ sm4_pkg::FK_1;
		k[2] = key_lo[63:32] ^ sm4_pkg::FK_2;
		k[3] = key_lo[31:0] ^ sm4_pkg::FK_3;
		for (int i = 0; i < 32; i++) begin
			nk = k[0] ^ mix_key(sbox_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i)));
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = nk;
			if (encrypt) begin
				subkeys[i] = nk;
			end else begin
				subkeys[31 - i] = nk;
			end
		end
		keys_valid = 1'b1;
	endfunction

	function automatic cipher_block_t encipher(input logic [63:0] hi, lo, input logic last);
		logic [31:0] x [4];
		logic [31:0] nx;
		cipher_block_t r;
		x[0] = hi[63:32];
		x[1] = hi[31:0];
		x[2] = lo[63:32];
		x[3] = lo[31:0];
		for (int i = 0; i < 32; i++) begin
			nx = x[0] ^ mix_data(sbox_word(x[1] ^ x[2] ^ x[3] ^ subkeys[i]));
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		r.hi = {x[3], x[2]};
		r.lo = {x[1], x[0]};
		r.last = last;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi = '0;
			key_lo = '0;
			encrypt = 1'b1;
			keys_valid = 1'b0;
			results_due.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sm4_pkg::REG_KEY_HIGH: begin
						key_hi = cfg_data;
						keys_valid = 1'b0;
					end
					sm4_pkg::REG_KEY_LOW: begin
						key_lo = cfg_data;
						keys_valid = 1'b0;
					end
					sm4_pkg::REG_ENC_MODE: begin
						encrypt = cfg_data[0];
						keys_valid = 1'b0;
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (!keys_valid)
					expand_subkeys();
				results_due.push_back(encipher(s_tdata[63:0], s_tdata[127:64], s_tlast));
			end
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result item: %h last %b", m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					if (m_tdata[63:0] !== want.hi) begin
						$error("result_high: expected %h, got %h", want.hi, m_tdata[63:0]);
						mismatches++;
					end
					if (m_tdata[127:64] !== want.lo) begin
						$error("result_low: expected %h, got %h", want.lo, m_tdata[127:64]);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("final_out: expected %b, got %b", want.last, m_tlast);
						mismatches++;
					end
				end
			end
			pending <= results_due.size();
		end
	end

endmodule

// ===== tb/sm4_block_cipher_test.sv =====
module sm4_block_cipher_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  REG_SPARE   = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 200;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // [63:0] block_high, [127:64] block_low
	logic         s_tlast;   // final_block
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // [63:0] result_high, [127:64] result_low
	logic         m_tlast;   // final_out

	int unsigned mismatches;
	int unsigned pending;
	int unsigned cycle_count = 0;
	int unsigned blocks_sent = 0;
	int unsigned settings = 0;
	bit          tx_gaps = 1'b0;
	bit          rx_stalls = 1'b0;
	bit          hold_request = 1'b0;

	sm4_block_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	sm4_block_cipher_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[sm4_block_cipher] ERROR");
			$finish;
		end
	end

	// output side: random stall bursts, plus one long hold-off on request
	initial begin : result_sink
		int unsigned burst;
		bit          hold_done;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				burst = $urandom_range(1, 18);
				repeat (burst) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] rand_half();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_block(input logic [63:0] hi, lo, input logic last);
		s_tvalid <= 1'b1;
		s_tdata <= {lo, hi};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		blocks_sent++;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// which: bit 0 key_high, bit 1 key_low, bit 2 mode bit, bit 3 unused index
	task automatic set_regs(input logic [3:0] which, input logic [63:0] hi, lo,
			input logic mode);
		drain();
		if (which[0])
			write_reg(sm4_pkg::REG_KEY_HIGH, hi);
		if (which[1])
			write_reg(sm4_pkg::REG_KEY_LOW, lo);
		if (which[2])
			write_reg(sm4_pkg::REG_ENC_MODE,
				{$urandom, 16'($urandom_range(0, 32767)), 15'h0, mode});
		if (which[3])
			write_reg(REG_SPARE, {$urandom, $urandom});
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset key, encrypt
		send_block('0, '0, 1'b1);
		send_block('1, '1, 1'b0);

		set_regs(4'b0111, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
		send_block('0, '1, 1'b0);

		set_regs(4'b0100, '0, '0, 1'b0);
		send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b1);
		send_block('1, '0, 1'b1);

		// write to the unused index must leave the keys alone
		set_regs(4'b1000, '0, '0, 1'b0);
		send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);

		set_regs(4'b0011, '1, '1, 1'b0);
		send_block('0, '0, 1'b0);
		send_block('1, '1, 1'b1);
		send_block(64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 1'b0);

		set_regs(4'b0100, '0, '0, 1'b1);
		send_block('0, '0, 1'b1);
		send_block('1, '1, 1'b0);
		send_block(64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5, 1'b1);

		set_regs(4'b0111, '0, 64'h8000000000000001, 1'b0);
		send_block(64'h8000000000000001, '0, 1'b1);
		send_block('0, 64'h0000000100000001, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			set_regs(4'($urandom_range(1, 15)), rand_half(), rand_half(), 1'($urandom));
			tx_gaps = (phase % 3 != 1) && phase != 2 && phase != PHASES - 1;
			rx_stalls = (phase % 3 != 0) && phase != PHASES - 1;
			if (phase == 2)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS)
				send_block(rand_half(), rand_half(), $urandom_range(0, 3) == 0);
		end

		drain();
		repeat (40) @(posedge clk);
		$display("sent %0d blocks under %0d register settings: both directions, extreme keys,",
			blocks_sent, settings);
		$display("unused register index, output hold-off and random stalls on both sides");
		if (mismatches == 0 && pending == 0) begin
			$display("[sm4_block_cipher] OK");
		end else begin
			$display("[sm4_block_cipher] ERROR");
		end
		$finish;
	end

endmodule
